### design/csem_pkg.sv
// Shared types and constants for the counting semaphore table.
// Holds table sizing, command and status codes and the payload structs.
// No dependencies.
`default_nettype none

package csem_pkg;

  // Table sizing
  localparam int NUM_SEMS    = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int ID_W        = $clog2(NUM_SEMS);
  localparam int ENTRY_W     = 2 * COUNT_WIDTH;

  typedef logic [ID_W-1:0]        id_t;
  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [ENTRY_W-1:0]     entry_t;

  localparam cnt_t CNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_FREE   = 2'd1,
    OP_DOWN   = 2'd2,
    OP_UP     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_BAD_ID      = 3'd1,
    STAT_NOT_ALLOC   = 3'd2,
    STAT_FULL        = 3'd3,
    STAT_DIFFERS     = 3'd4,
    STAT_WOULD_BLOCK = 3'd5,
    STAT_OVERFLOW    = 3'd6
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

  // Command transfer
  typedef struct packed {
    op_t         cmd;
    logic [7:0]  sem_id;
    logic [15:0] load_count;
  } req_t;

  // Result transfer
  typedef struct packed {
    status_t     status;
    logic [5:0]  slot_id;
    logic [15:0] count_after;
  } rsp_t;

  // Update of the in-use bits
  typedef struct packed {
    logic set;
    logic clr;
    id_t  idx;
  } slot_upd_t;

  // View of the in-use bits
  typedef struct packed {
    logic found;
    id_t  free_idx;
    logic bit_at;
  } slot_stat_t;

endpackage

`default_nettype wire

### design/counting_semaphore_table.sv
// Top level of the counting semaphore table.
// Depends on csem_pkg, csem_ram and csem_slot_map.
//
// Usage:
//   A command transfers on a rising edge with start high and busy low. The
//   command struct carries the operation (create, free, down, up), the slot
//   index and the initial count for create.
//   Every command gives exactly one result: rsp is valid for one cycle
//   while done is high. The receiver cannot stall, so it must take rsp in
//   that cycle.
//   done is registered: the result transfers once the command has passed
//   the EXEC state and the done register. busy is high while the command
//   is in the EXEC state, so no new command is taken while one executes.
//   This follows from the read-modify-write of the count RAM: the
//   registered read, then the update and write back.
//   Only one command is in flight, so no forwarding is needed.
//   Counts and initial counts live in one RAM; the in-use bits are flops.
//   Reset clears the in-use bits at once, so the table is usable as soon
//   as reset is released, with no clearing pass. A slot that is not in
//   use reads as zero whatever its RAM word holds.
`default_nettype none

module counting_semaphore_table (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire csem_pkg::req_t req,
  output logic                busy,
  output logic                done,
  output csem_pkg::rsp_t      rsp
);

  import csem_pkg::*;

  fsm_t       state;
  fsm_t       state_next;
  logic       accept;
  logic       exec;

  op_t        op_q;
  id_t        id_q;
  logic       bad_q;
  cnt_t       init_q;

  slot_upd_t  upd;
  slot_stat_t stat;

  logic       ram_we;
  id_t        ram_waddr;
  entry_t     ram_wdata;
  entry_t     ram_rdata;
  cnt_t       cur_cnt;
  cnt_t       cur_init;

  rsp_t       rsp_next;
  logic       done_next;

  assign accept = start && !busy;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (accept) begin
          state_next = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        state_next = FSM_IDLE;
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    case (state)
      FSM_IDLE: begin
        busy = 1'b0;
        exec = 1'b0;
      end
      FSM_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
        exec = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the command on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= req.cmd;
      id_q   <= req.sem_id[ID_W-1:0];
      bad_q  <= ({1'b0, req.sem_id} >= 9'(NUM_SEMS));
      init_q <= COUNT_WIDTH'(32'(req.load_count));
    end
  end

  // Count and initial count storage
  csem_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SEMS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (req.sem_id[ID_W-1:0]),
    .rdata (ram_rdata)
  );

  csem_slot_map u_slot_map (
    .clk    (clk),
    .rst    (rst),
    .upd    (upd),
    .rd_idx (id_q),
    .stat   (stat)
  );

  assign cur_cnt  = ram_rdata[COUNT_WIDTH-1:0];
  assign cur_init = ram_rdata[ENTRY_W-1:COUNT_WIDTH];

  // Modify and write back
  always_comb begin
    upd                  = '0;
    upd.idx              = id_q;
    ram_we               = 1'b0;
    ram_waddr            = id_q;
    ram_wdata            = {cur_init, cur_cnt};
    rsp_next.status      = STAT_OK;
    rsp_next.slot_id     = '0;
    rsp_next.count_after = '0;
    if (exec) begin
      if (op_q == OP_CREATE) begin
        if (stat.found) begin
          upd.set              = 1'b1;
          upd.idx              = stat.free_idx;
          ram_we               = 1'b1;
          ram_waddr            = stat.free_idx;
          ram_wdata            = {init_q, init_q};
          rsp_next.slot_id     = 6'(32'(stat.free_idx));
          rsp_next.count_after = 16'(32'(init_q));
        end else begin
          rsp_next.status = STAT_FULL;
        end
      end else if (bad_q) begin
        rsp_next.status = STAT_BAD_ID;
      end else if (!stat.bit_at) begin
        rsp_next.status = STAT_NOT_ALLOC;
      end else begin
        case (op_q)
          OP_FREE: begin
            if (cur_cnt != cur_init) begin
              rsp_next.status      = STAT_DIFFERS;
              rsp_next.count_after = 16'(32'(cur_cnt));
            end else begin
              upd.clr = 1'b1;
            end
          end
          OP_DOWN: begin
            if (cur_cnt == '0) begin
              rsp_next.status = STAT_WOULD_BLOCK;
            end else begin
              ram_we               = 1'b1;
              ram_wdata            = {cur_init, cur_cnt - COUNT_WIDTH'(1)};
              rsp_next.count_after = 16'(32'(cur_cnt - COUNT_WIDTH'(1)));
            end
          end
          OP_UP: begin
            if (cur_cnt == CNT_MAX) begin
              rsp_next.status      = STAT_OVERFLOW;
              rsp_next.count_after = 16'(32'(cur_cnt));
            end else begin
              ram_we               = 1'b1;
              ram_wdata            = {cur_init, cur_cnt + COUNT_WIDTH'(1)};
              rsp_next.count_after = 16'(32'(cur_cnt + COUNT_WIDTH'(1)));
            end
          end
          default: begin
            rsp_next.status = STAT_OK;
          end
        endcase
      end
    end
  end

  assign done_next = exec;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

### design/csem_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module csem_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/csem_slot_map.sv
// In-use bit per semaphore slot and the lowest-free-slot encoder.
// Depends on csem_pkg.
`default_nettype none

module csem_slot_map (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire csem_pkg::slot_upd_t    upd,
  input  wire csem_pkg::id_t          rd_idx,
  output csem_pkg::slot_stat_t        stat
);

  import csem_pkg::*;

  logic [NUM_SEMS-1:0] in_use;
  logic [NUM_SEMS-1:0] in_use_next;
  logic [NUM_SEMS-1:0] free_bits;
  logic [NUM_SEMS-1:0] lowest;
  id_t                 free_idx;

  // Apply set and clear
  always_comb begin
    in_use_next = in_use;
    if (upd.set) begin
      in_use_next[upd.idx] = 1'b1;
    end
    if (upd.clr) begin
      in_use_next[upd.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else begin
      in_use <= in_use_next;
    end
  end

  // Isolate the lowest free bit, then encode its position
  assign free_bits = ~in_use;
  assign lowest    = free_bits & (~free_bits + NUM_SEMS'(1));

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < NUM_SEMS; i++) begin
      if (lowest[i]) begin
        free_idx = free_idx | ID_W'(i);
      end
    end
  end

  assign stat.found    = |free_bits;
  assign stat.free_idx = free_idx;
  assign stat.bit_at   = in_use[rd_idx];

endmodule

`default_nettype wire

### design/csem_checker.sv
// Port-level checks for the counting semaphore table, bound to the top level.
// Depends on csem_pkg and counting_semaphore_table.
`default_nettype none

module csem_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire csem_pkg::req_t req,
  input wire logic           busy,
  input wire logic           done,
  input wire csem_pkg::rsp_t rsp
);

  import csem_pkg::*;

  // A transfer holds the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after command transfer");

  // Every transfer yields its result after the EXEC state and the done register
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result missing after command transfer");

  // A result only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without work");

  // Only a successful create reports a slot
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != STAT_OK) |-> (rsp.slot_id == 6'd0))
    else $error("slot reported on failed command");

  // A rejected id or a full table reports no count
  a_bad_id_count: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == STAT_BAD_ID || rsp.status == STAT_FULL))
      |-> (rsp.count_after == 16'd0))
    else $error("count reported on rejected command");

endmodule

bind counting_semaphore_table csem_checker u_csem_checker (.*);

`default_nettype wire

### tb/csem_table_checker.sv
// Checker for the counting semaphore table: watches command and result transfers.
// Predicts each result from its own copy of the table and compares field by field.
// Depends on csem_pkg.
module csem_table_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  csem_pkg::req_t req,
  input  logic           done,
  input  csem_pkg::rsp_t rsp,
  output int             mismatches,
  output int             outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  import csem_pkg::*;

  // Shadow copy of the semaphore table
  bit   slot_busy [NUM_SEMS];
  cnt_t slot_cnt  [NUM_SEMS];
  cnt_t slot_init [NUM_SEMS];

  rsp_t expected_rsp[$];
  int   err_cnt;

  assign mismatches = err_cnt;

  // Apply one command to the shadow table and return the result it must give
  function automatic rsp_t run_semaphore_op(req_t r);
    rsp_t        res;
    int unsigned id;
    int          i;
    bit          claimed;
    res         = '0;
    res.status  = STAT_OK;
    id          = r.sem_id;
    claimed     = 1'b0;
    if (r.cmd == OP_CREATE) begin
      // Claim the lowest free slot
      for (i = 0; i < NUM_SEMS; i++) begin
        if (!claimed && !slot_busy[i]) begin
          claimed         = 1'b1;
          slot_busy[i]    = 1'b1;
          slot_cnt[i]     = cnt_t'(r.load_count);
          slot_init[i]    = cnt_t'(r.load_count);
          res.slot_id     = 6'(i);
          res.count_after = 16'(slot_cnt[i]);
        end
      end
      if (!claimed) res.status = STAT_FULL;
    end else if (id >= NUM_SEMS) begin
      res.status = STAT_BAD_ID;
    end else if (!slot_busy[id]) begin
      res.status      = STAT_NOT_ALLOC;
      res.count_after = 16'(slot_cnt[id]);
    end else begin
      case (r.cmd)
        OP_FREE: begin
          if (slot_cnt[id] != slot_init[id]) begin
            res.status      = STAT_DIFFERS;
            res.count_after = 16'(slot_cnt[id]);
          end else begin
            slot_busy[id] = 1'b0;
            slot_cnt[id]  = '0;
            slot_init[id] = '0;
          end
        end
        OP_DOWN: begin
          if (slot_cnt[id] == '0) begin
            res.status = STAT_WOULD_BLOCK;
          end else begin
            slot_cnt[id]    = slot_cnt[id] - 1'b1;
            res.count_after = 16'(slot_cnt[id]);
          end
        end
        default: begin
          // Saturate at the top of the count range
          if (slot_cnt[id] == CNT_MAX) begin
            res.status = STAT_OVERFLOW;
          end else begin
            slot_cnt[id] = slot_cnt[id] + 1'b1;
          end
          res.count_after = 16'(slot_cnt[id]);
        end
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    int   i;
    if (rst) begin
      for (i = 0; i < NUM_SEMS; i++) begin
        slot_busy[i] = 1'b0;
        slot_cnt[i]  = '0;
        slot_init[i] = '0;
      end
      expected_rsp.delete();
      err_cnt = 0;
    end else begin
      // Compare a result transfer with the oldest prediction
      if (done) begin
        if (expected_rsp.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: result with none expected: status %0d slot %0d count %0h",
                     $realtime, rsp.status, rsp.slot_id, rsp.count_after);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status !== want.status || rsp.slot_id !== want.slot_id ||
              rsp.count_after !== want.count_after) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: expected status %0d slot %0d count %0h, got %0d %0d %0h",
                       $realtime, want.status, want.slot_id, want.count_after,
                       rsp.status, rsp.slot_id, rsp.count_after);
          end
        end
      end
      // Predict the result of a command transfer
      if (start && !busy) expected_rsp.push_back(run_semaphore_op(req));
    end
    outstanding <= expected_rsp.size();
  end

endmodule

### tb/tb_counting_semaphore_table.sv
// Testbench top for the counting semaphore table: clock, reset, commands, verdict.
// Depends on csem_pkg, counting_semaphore_table and csem_table_checker.
module tb_counting_semaphore_table;

  timeunit 1ns;
  timeprecision 1ps;

  import csem_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int IDLE_LIMIT   = 400;
  localparam int DRAIN_CYCLES = 8;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  int mismatch_total;
  int pending_total;
  int sent_cnt   = 0;
  int burst_left = 8;
  int idle_cycles = 0;

  always #6 clk = ~clk;

  counting_semaphore_table u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  csem_table_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .rsp         (rsp),
    .mismatches  (mismatch_total),
    .outstanding (pending_total)
  );

  // Drop the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold one command until it transfers, then idle at the end of a burst
  task automatic send(op_t op, logic [7:0] id, logic [15:0] val);
    req_t r;
    r.cmd        = op;
    r.sem_id     = id;
    r.load_count = val;
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_cnt++;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
  endtask

  // Bias counts toward the ends of the range
  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'hFFFE;
      3:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // Low slots are the ones most likely in use
  function automatic logic [7:0] pick_slot();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(NUM_SEMS, 255));
      1, 2:    return 8'($urandom_range(0, NUM_SEMS - 1));
      default: return 8'($urandom_range(0, 15));
    endcase
  endfunction

  initial begin : stimulus
    logic [7:0] id;
    int         n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: unused and out-of-range slots, count extremes, free rules
    send(OP_UP,     8'd0,   16'h1234);
    send(OP_DOWN,   8'd5,   16'h0000);
    send(OP_FREE,   8'd63,  16'hFFFF);
    send(OP_FREE,   8'd64,  16'h0000);
    send(OP_UP,     8'd255, 16'h0000);
    send(OP_CREATE, 8'd200, 16'h0000);
    send(OP_DOWN,   8'd0,   16'h0000);
    send(OP_CREATE, 8'd0,   16'hFFFF);
    send(OP_UP,     8'd1,   16'h0000);
    send(OP_DOWN,   8'd1,   16'h0000);
    send(OP_FREE,   8'd1,   16'h0000);
    send(OP_UP,     8'd1,   16'h0000);
    send(OP_FREE,   8'd1,   16'h0000);
    send(OP_CREATE, 8'd255, 16'h0001);
    send(OP_UP,     8'd0,   16'h0000);
    send(OP_FREE,   8'd0,   16'h0000);
    send(OP_DOWN,   8'd0,   16'h0000);
    send(OP_FREE,   8'd0,   16'h0000);
    send(OP_CREATE, 8'd0,   16'hAAAA);
    send(OP_CREATE, 8'd0,   16'h5555);
    send(OP_DOWN,   8'd128, 16'h0000);

    // Random: create bursts, up/down runs ending in a free, saturation and noise
    n = sent_cnt + RANDOM_ITEMS;
    while (sent_cnt < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat ($urandom_range(1, 20)) send(OP_CREATE, 8'($urandom), pick_count());
        end
        3, 4, 5: begin
          id = pick_slot();
          if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(0, 4)) send(OP_UP, id, 16'($urandom));
            repeat ($urandom_range(0, 4)) send(OP_DOWN, id, 16'($urandom));
          end else begin
            repeat ($urandom_range(0, 4)) send(OP_DOWN, id, 16'($urandom));
            repeat ($urandom_range(0, 4)) send(OP_UP, id, 16'($urandom));
          end
          send(OP_FREE, id, 16'($urandom));
        end
        6: repeat ($urandom_range(1, 6)) send(OP_FREE, pick_slot(), 16'($urandom));
        7: begin
          id = pick_slot();
          repeat ($urandom_range(1, 3)) send(OP_UP, id, 16'($urandom));
        end
        8: begin
          repeat ($urandom_range(1, 8))
            send(op_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
        end
        default: begin
          id = pick_slot();
          repeat ($urandom_range(1, 4)) send(OP_DOWN, id, 16'($urandom));
        end
      endcase
    end
    if (start) start <= 1'b0;

    // Drain outstanding results, then allow the pipeline to settle
    @(posedge clk);
    while (pending_total != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
